/* rtl/core/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// shared types and codes for the bitmap first-fit allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

  // bitmap memory word geometry
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);

  // fixed field widths on the ports
  localparam int FIELD_W  = 14;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // default bitmap size and limit register reset
  localparam int                 DEF_MAP_ENTRIES = 8192;
  localparam logic [FIELD_W-1:0] LIMIT_RESET     = 14'd8192;

  // request codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  // result of searching one bitmap word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } scan_res_t;

endpackage

/* rtl/core/bfa_word_scan.sv */
// ----------------------------------------------------------------------------
// bfa_word_scan
// finds the lowest clear bit of a bitmap word among the bits allowed by a mask
// ----------------------------------------------------------------------------
module bfa_word_scan
  import bfa_pkg::*;
(
  input  word_t     map_word,
  input  word_t     valid_mask,
  output scan_res_t res
);

  word_t free_bits;

  assign free_bits = ~map_word & valid_mask;

  // scan high to low so the lowest free bit wins
  always_comb begin
    res.found   = 1'b0;
    res.bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        res.found   = 1'b1;
        res.bit_idx = BIT_W'(i);
      end
    end
  end

endmodule

/* rtl/core/bitmap_first_free_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_unit
// first-fit entry allocator over a one-bit-per-entry usage bitmap
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             word
//  in_      input      in_valid / in_ready   in_op, in_entry_number
//  out_     output     out_valid / out_ready out_granted_number, out_status,
//                                            out_free_count
//  cfg_     input      cfg_valid / cfg_ready cfg_entry_limit
//
// allocate: accept, then one bitmap word per cycle from word 0 until a
//   free bit or the limit, then post the result
// free, reserve: accept and read, modify and write back, post; rejects
//   go straight from accept to post
// after reset a clearing pass writes zeros over all ceil(MAP_ENTRIES/32)
//   words before in_ready rises
// a new word is accepted while the previous result waits in the output
//   register; a stalled output only holds the block at the posting step
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_unit
  import bfa_pkg::*;
#(
  parameter int MAP_ENTRIES = DEF_MAP_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [FIELD_W-1:0]  in_entry_number,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [FIELD_W-1:0]  out_granted_number,
  output logic [STATUS_W-1:0] out_status,
  output logic [FIELD_W-1:0]  out_free_count,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [FIELD_W-1:0]  cfg_entry_limit
);

  // geometry
  localparam int MAP_WORDS = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LIM_W     = $clog2(MAP_ENTRIES + 1);
  localparam int IDX_W     = WORD_AW + BIT_W;
  localparam int MAX_A     = (LIM_W > IDX_W) ? LIM_W : IDX_W;
  localparam int MAX_B     = (MAX_A > FIELD_W) ? MAX_A : FIELD_W;
  localparam int EXT_W     = MAX_B + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_t;

  // control state
  state_t               state_r,      state_nxt;
  logic [FIELD_W-1:0]   limit_r,      limit_nxt;
  logic [LIM_W-1:0]     used_r,       used_nxt;
  logic                 out_valid_r,  out_valid_nxt;
  logic [WORD_AW-1:0]   word_r,       word_nxt;
  // request payload
  logic [BIT_W-1:0]     bit_r,        bit_nxt;
  logic                 want_r,       want_nxt;
  logic [FIELD_W-1:0]   res_grant_r,  res_grant_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [FIELD_W-1:0]   out_grant_r,  out_grant_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [FIELD_W-1:0]   out_free_r,   out_free_nxt;

  // bitmap memory, one read and one write port
  word_t                mem [MAP_WORDS];
  word_t                rd_data_r;
  logic                 mem_re;
  logic [WORD_AW-1:0]   mem_ra;
  logic                 mem_we;
  logic [WORD_AW-1:0]   mem_wa;
  word_t                mem_wd;

  // datapath
  logic [EXT_W-1:0]     eff_ext;
  logic [EXT_W-1:0]     num_ext;
  logic [EXT_W-1:0]     idx_ext;
  logic [EXT_W-1:0]     base_ext;
  logic [EXT_W-1:0]     rem_ext;
  logic [EXT_W-1:0]     used_ext;
  word_t                scan_mask;
  word_t                bit_onehot;
  logic                 last_word;
  logic                 range_bad;
  scan_res_t            scan_res;

  // effective limit is the register clamped to the map size
  always_comb begin
    if (EXT_W'(limit_r) > EXT_W'(MAP_ENTRIES)) begin
      eff_ext = EXT_W'(MAP_ENTRIES);
    end else begin
      eff_ext = EXT_W'(limit_r);
    end
  end

  assign num_ext   = EXT_W'(in_entry_number);
  assign idx_ext   = num_ext - EXT_W'(1);
  assign range_bad = (num_ext == '0) || (num_ext > eff_ext);
  assign used_ext  = EXT_W'(used_r);

  // bits of the current word that lie below the limit
  assign base_ext  = EXT_W'({word_r, {BIT_W{1'b0}}});
  assign rem_ext   = eff_ext - base_ext;
  assign last_word = (base_ext + EXT_W'(WORD_BITS)) >= eff_ext;

  always_comb begin
    if (rem_ext >= EXT_W'(WORD_BITS)) begin
      scan_mask = '1;
    end else begin
      scan_mask = (word_t'(1) << rem_ext[BIT_W-1:0]) - word_t'(1);
    end
  end

  bfa_word_scan u_scan (
    .map_word   (rd_data_r),
    .valid_mask (scan_mask),
    .res        (scan_res)
  );

  assign bit_onehot = word_t'(1) << bit_r;

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    used_nxt       = used_r;
    word_nxt       = word_r;
    bit_nxt        = bit_r;
    want_nxt       = want_r;
    res_grant_nxt  = res_grant_r;
    res_status_nxt = res_status_r;
    out_grant_nxt  = out_grant_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    mem_re         = 1'b0;
    mem_ra         = '0;
    mem_we         = 1'b0;
    mem_wa         = word_r;
    mem_wd         = '0;

    // host must write the limit only with no request in flight; not enforced
    if (cfg_valid) begin
      limit_nxt = cfg_entry_limit;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = word_r;
        mem_wd   = '0;
        word_nxt = word_r + WORD_AW'(1);
        if (word_r == WORD_AW'(MAP_WORDS - 1)) begin
          word_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          res_grant_nxt  = '0;
          res_status_nxt = ST_OK;
          want_nxt       = (in_op == OP_RESERVE);
          bit_nxt        = idx_ext[BIT_W-1:0];
          word_nxt       = WORD_AW'(idx_ext >> BIT_W);
          state_nxt      = S_DONE;
          case (in_op) inside
            OP_ALLOC: begin
              if (eff_ext == '0) begin
                res_status_nxt = ST_FULL;
              end else begin
                // first word of the scan
                mem_re    = 1'b1;
                mem_ra    = '0;
                word_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            OP_FREE, OP_RESERVE: begin
              if (range_bad) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = WORD_AW'(idx_ext >> BIT_W);
                state_nxt = S_UPDATE;
              end
            end
            default: begin
              // unused code, answered with the current count
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_res.found) begin
          mem_we         = 1'b1;
          mem_wa         = word_r;
          mem_wd         = rd_data_r | (word_t'(1) << scan_res.bit_idx);
          used_nxt       = used_r + LIM_W'(1);
          res_grant_nxt  = FIELD_W'(base_ext + EXT_W'(scan_res.bit_idx) + EXT_W'(1));
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else if (last_word) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          // fetch the next word while this one is examined
          mem_re   = 1'b1;
          mem_ra   = word_r + WORD_AW'(1);
          word_nxt = word_r + WORD_AW'(1);
        end
      end

      S_UPDATE: begin
        state_nxt = S_DONE;
        if ((|(rd_data_r & bit_onehot)) != want_r) begin
          mem_we = 1'b1;
          mem_wa = word_r;
          if (want_r) begin
            mem_wd   = rd_data_r | bit_onehot;
            used_nxt = used_r + LIM_W'(1);
          end else begin
            mem_wd = rd_data_r & ~bit_onehot;
            if (used_r != '0) begin
              used_nxt = used_r - LIM_W'(1);
            end
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_grant_nxt  = res_grant_r;
          out_status_nxt = res_status_r;
          if (eff_ext > used_ext) begin
            out_free_nxt = FIELD_W'(eff_ext - used_ext);
          end else begin
            out_free_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    word_r       <= word_nxt;
    bit_r        <= bit_nxt;
    want_r       <= want_nxt;
    res_grant_r  <= res_grant_nxt;
    res_status_r <= res_status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
    state_r      <= state_nxt;
    limit_r      <= limit_nxt;
    used_r       <= used_nxt;
    out_valid_r  <= out_valid_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      word_r      <= '0;
      limit_r     <= LIMIT_RESET;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_granted_number = out_grant_r;
  assign out_status         = out_status_r;
  assign out_free_count     = out_free_r;

`ifndef ASSERT_OFF
  // a granted number always comes with an ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_grant_r != '0) |-> (out_status_r == ST_OK))
    else $error("granted number with non-ok status");

  // the used count never exceeds the map
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (EXT_W'(used_r) <= EXT_W'(MAP_ENTRIES)))
    else $error("used count above map size");

  // the scan never looks at a word wholly beyond the limit
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (base_ext < eff_ext))
    else $error("scan beyond limit");

  // a successful allocate adds exactly one to the used count
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_res.found) |=> (used_r == $past(used_r) + LIM_W'(1)))
    else $error("allocate did not bump used count");
`endif

endmodule

/* sim/bitmap_first_free_allocator_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_unit_tb
// self-checking bench for the first-fit bitmap allocator: drives allocate,
// free, reserve and unused requests under several entry limits and flow
// control patterns, and checks every result word against an in-bench model
// of the usage bitmap and its used count
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_unit_tb;
  import bfa_pkg::*;

  localparam int MAP_ENTRIES = DEF_MAP_ENTRIES;

  // request code that the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // every request answers, so only a short settle is needed before a limit write
  localparam int SETTLE_CYCLES = 4;
  // tail watch after the drain, longer than the longest allocate scan
  localparam int TAIL_CYCLES   = MAP_ENTRIES / WORD_BITS + 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 55;
  localparam int MAX_FIELD     = (1 << FIELD_W) - 1;

  // one expected result word
  typedef struct {
    logic [FIELD_W-1:0]  granted_number;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  free_count;
  } alloc_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op = OP_ALLOC;
  logic [FIELD_W-1:0]  in_entry_number = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [FIELD_W-1:0]  out_granted_number;
  logic [STATUS_W-1:0] out_status;
  logic [FIELD_W-1:0]  out_free_count;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [FIELD_W-1:0]  cfg_entry_limit = '0;

  // model state: usage bitmap, number of set bits, limit register
  logic                usage_bits [MAP_ENTRIES];
  int unsigned         used_count;
  logic [FIELD_W-1:0]  entry_limit_q;

  alloc_result_t       pending_results [$];
  int                  mismatch_count = 0;

  // flow control knobs, percent of cycles spent idle or stalled
  int unsigned         sender_idle_pct = 0;
  int unsigned         receiver_stall_pct = 0;

  bitmap_first_free_allocator_unit #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_entry_number    (in_entry_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_granted_number (out_granted_number),
    .out_status         (out_status),
    .out_free_count     (out_free_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entry_limit    (cfg_entry_limit)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // limit register clamped to the bitmap size
  function automatic int unsigned effective_limit();
    return (entry_limit_q > MAP_ENTRIES) ? MAP_ENTRIES : int'(entry_limit_q);
  endfunction

  // updates the model bitmap for one accepted request and returns its answer
  function automatic alloc_result_t predict_allocator(input logic [OP_W-1:0] op,
                                                      input logic [FIELD_W-1:0] num);
    alloc_result_t r;
    int unsigned   lim;
    int unsigned   idx;
    logic          want;
    lim              = effective_limit();
    r.granted_number = '0;
    r.status         = ST_OK;
    case (op) inside
      OP_ALLOC: begin
        // first clear bit below the limit, lowest entry first
        r.status = ST_FULL;
        idx      = 0;
        while (idx < lim && r.status == ST_FULL) begin
          if (!usage_bits[idx]) begin
            usage_bits[idx]  = 1'b1;
            used_count++;
            r.granted_number = FIELD_W'(idx + 1);
            r.status         = ST_OK;
          end
          idx++;
        end
      end
      OP_FREE, OP_RESERVE: begin
        if (num == 0 || num > lim) begin
          r.status = ST_RANGE;
        end else begin
          // count moves only when the bit really flips
          idx  = num - 1;
          want = (op == OP_RESERVE);
          if (usage_bits[idx] != want) begin
            usage_bits[idx] = want;
            if (want) used_count++;
            else if (used_count > 0) used_count--;
          end
        end
      end
      default: ;  // unused code leaves everything alone
    endcase
    // bits above a lowered limit still count, so saturate at zero
    r.free_count = (lim > used_count) ? FIELD_W'(lim - used_count) : '0;
    return r;
  endfunction

  // result checker, sampled on the rising edge
  always @(posedge clk) begin : check_results
    alloc_result_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: granted=%0d status=%0d free=%0d",
                   out_granted_number, out_status, out_free_count);
      end else begin
        exp_word = pending_results.pop_front();
        if (out_granted_number !== exp_word.granted_number ||
            out_status         !== exp_word.status ||
            out_free_count     !== exp_word.free_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: expected granted=%0d status=%0d free=%0d,",
                      " got granted=%0d status=%0d free=%0d"},
                     exp_word.granted_number, exp_word.status, exp_word.free_count,
                     out_granted_number, out_status, out_free_count);
        end
      end
    end
  end

  task automatic set_flow(input int unsigned sender_pct, input int unsigned receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // sends one request word; the model is updated at the accepting edge
  task automatic send_word(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] num);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_entry_number <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_allocator(op, num));
  endtask

  // drops valid and holds off until every answer is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // limit register write, only with the block idle
  task automatic write_entry_limit(input logic [FIELD_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_entry_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    entry_limit_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random request, mostly legal numbers biased towards the low, busy end
  task automatic send_random_request();
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] num;
    int unsigned        lim;
    int unsigned        pick;
    lim  = effective_limit();
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = OP_ALLOC;
    else if (pick < 70) op = OP_FREE;
    else if (pick < 94) op = OP_RESERVE;
    else                op = OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 10)      num = FIELD_W'($urandom_range(0, MAX_FIELD));
    else if (pick < 12) num = '0;
    else if (pick < 15) num = FIELD_W'(lim + 1);
    else if (pick < 18) num = FIELD_W'(lim);
    else if (lim == 0)  num = '0;
    else if (pick < 60) num = FIELD_W'($urandom_range(1, (lim < 64) ? lim : 64));
    else                num = FIELD_W'($urandom_range(1, lim));
    send_word(op, num);
  endtask

  // plain requests at the reset limit, including the no-change cases
  task automatic test_basic_requests();
    set_flow(0, 0);
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, 14'h3FFF);     // number is ignored on allocate
    send_word(OP_FREE, 14'd1);
    send_word(OP_ALLOC, '0);           // reuses entry 1
    send_word(OP_RESERVE, 14'd3);
    send_word(OP_ALLOC, '0);           // skips the reserved entry
    send_word(OP_FREE, 14'd0);         // zero is out of range
    send_word(OP_RESERVE, 14'd8192);   // top entry
    send_word(OP_RESERVE, 14'd8192);   // already used, no change
    send_word(OP_FREE, 14'd5);         // already free, no change
    send_word(OP_FREE, 14'd8193);      // just past the limit
    send_word(OP_RESERVE, 14'h3FFF);
    send_word(OP_UNUSED, 14'h3FFF);
    send_word(OP_UNUSED, 14'd0);
  endtask

  // zero limit, lowered limit with saturated free count, clamped limit
  task automatic test_limit_corners();
    set_flow(11, 11);
    write_entry_limit(14'd0);
    send_word(OP_ALLOC, '0);
    send_word(OP_FREE, 14'd1);
    send_word(OP_RESERVE, 14'd1);
    write_entry_limit(14'd2);
    send_word(OP_ALLOC, '0);           // low entries already taken
    send_word(OP_FREE, 14'd2);
    send_word(OP_ALLOC, '0);
    send_word(OP_RESERVE, 14'd3);
    write_entry_limit(14'h3FFF);       // clamps to the map size
    send_word(OP_FREE, 14'd8192);
    send_word(OP_FREE, 14'd8193);
  endtask

  // sender stops mid-stream until the last answer is in
  task automatic test_drain_pause();
    set_flow(0, 83);
    write_entry_limit(14'd40);
    repeat (10) send_random_request();
    wait_drained();
    repeat (10) send_random_request();
  endtask

  // random traffic through several limits and flow control patterns
  task automatic test_random_traffic();
    logic [FIELD_W-1:0] lim_value;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       lim_value = 14'd8192;
        1:       lim_value = FIELD_W'($urandom_range(1, 48));
        2:       lim_value = 14'h3FFF;
        3:       lim_value = FIELD_W'($urandom_range(0, MAX_FIELD));
        4:       lim_value = 14'd1;
        5:       lim_value = FIELD_W'($urandom_range(49, 400));
        6:       lim_value = 14'd8193;
        default: lim_value = FIELD_W'($urandom_range(2, 24));
      endcase
      write_entry_limit(lim_value);
      case (phase % 4)
        0:       set_flow(0, 0);
        1:       set_flow(83, 0);
        2:       set_flow(0, 83);
        default: set_flow(11, 11);
      endcase
      repeat (PHASE_WORDS) send_random_request();
    end
  endtask

  // main sequence
  initial begin
    foreach (usage_bits[i]) usage_bits[i] = 1'b0;
    used_count    = 0;
    entry_limit_q = LIMIT_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_requests();
    test_limit_corners();
    test_drain_pause();
    test_random_traffic();

    // drain, then watch a while for stray result words
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("bitmap_first_free_allocator_unit_tb: done, clean");
    end else begin
      $display("bitmap_first_free_allocator_unit_tb: done, errors");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("bitmap_first_free_allocator_unit_tb: done, errors");
    $finish;
  end

endmodule
